// ===== rtl/fnvlp_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the fnv-1a keyword table
// no dependencies
package fnvlp_pkg;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned KEY_BYTES   = 15;
  localparam int unsigned KEY_BITS    = 120;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [63:0] key_low;
    logic [55:0] key_high;
    logic [3:0]  len;
    logic [3:0]  kind;
    logic [9:0]  offset;
  } slot_t;

  typedef struct packed {
    logic  op;
    logic  ok;
    slot_t slot;
  } req_t;

endpackage

// ===== rtl/fnvlp_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module fnvlp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fnvlp_queue.sv =====
`timescale 1ns / 1ps
// two-entry fifo between the hashing front end and the probe engine
// no dependencies
module fnvlp_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  logic [Width-1:0] data_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i && !full_o) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i && !empty_o) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if ((push_i && !full_o) && !(pop_i && !empty_o)) begin
      count_d = count_q + 2'd1;
    end else if (!(push_i && !full_o) && (pop_i && !empty_o)) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/fnvlp_front.sv =====
`timescale 1ns / 1ps
// front end: takes a request, masks the key, hashes it and reduces the hash to a home slot
// depends on fnvlp_pkg
module fnvlp_front #(
  parameter int unsigned Depth = fnvlp_pkg::TABLE_DEPTH,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic               opcode_i,
  input  logic [63:0]        key_low_i,
  input  logic [55:0]        key_high_i,
  input  logic [3:0]         key_length_i,
  input  logic [3:0]         entry_kind_i,
  input  logic [9:0]         entry_offset_i,
  output logic               busy_o,
  output logic               push_o,
  output fnvlp_pkg::req_t    push_req_o,
  output logic [IdxW-1:0]    push_idx_o,
  input  logic               full_i
);
  import fnvlp_pkg::*;

  // ceil(2^(32+IdxW) / Depth) gives an exact quotient for every 32-bit hash
  localparam logic [63:0] RecipFull =
    ((64'd1 << (32 + IdxW)) + 64'(Depth) - 64'd1) / 64'(Depth);
  localparam logic [32:0] Recip = RecipFull[32:0];

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]      state_q, state_d;
  req_t            req_q, req_d;
  logic [31:0]     hash_q, hash_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [1:0]      step_q, step_d;
  logic [47:0]     prod_lo_q, prod_lo_d;
  logic [48:0]     prod_hi_q, prod_hi_d;
  logic [31:0]     quot_q, quot_d;
  logic [IdxW-1:0] rem_q, rem_d;

  logic [KEY_BITS-1:0] key_in, key_masked, key_cur;
  logic [7:0]          cur_byte;
  logic [64:0]         prod_sum;
  logic                len_ok;

  assign key_in = {key_high_i, key_low_i};
  assign len_ok = (key_length_i != 4'd0) && (key_length_i <= 4'(KEY_BYTES));

  always_comb begin
    for (int b = 0; b < KEY_BITS / 8; b++) begin
      key_masked[8*b +: 8] = (4'(b) < key_length_i) ? key_in[8*b +: 8] : 8'd0;
    end
  end

  assign key_cur  = {req_q.slot.key_high, req_q.slot.key_low};
  assign cur_byte = key_cur[8*cnt_q +: 8];
  assign prod_sum = {prod_hi_q, 16'd0} + 65'(prod_lo_q);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    hash_d    = hash_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    prod_lo_d = prod_lo_q;
    prod_hi_d = prod_hi_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    case (state_q)
      S_IDLE: begin
        if (take_i) begin
          req_d.op            = opcode_i;
          req_d.ok            = len_ok;
          req_d.slot.key_low  = key_masked[63:0];
          req_d.slot.key_high = key_masked[119:64];
          req_d.slot.len      = key_length_i;
          req_d.slot.kind     = entry_kind_i;
          req_d.slot.offset   = entry_offset_i;
          hash_d  = FNV_BASIS;
          cnt_d   = 4'd0;
          step_d  = 2'd0;
          rem_d   = '0;
          state_d = len_ok ? S_HASH : S_PUSH;
        end
      end
      S_HASH: begin
        // one byte per cycle, multiply result registered
        hash_d = (hash_q ^ {24'd0, cur_byte}) * FNV_PRIME;
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == req_q.slot.len - 4'd1) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // reciprocal multiply: partial products, quotient, then remainder
        step_d = step_q + 2'd1;
        if (step_q == 2'd0) begin
          prod_lo_d = 48'(hash_q) * 48'(Recip[15:0]);
          prod_hi_d = 49'(hash_q) * 49'(Recip[32:16]);
        end else if (step_q == 2'd1) begin
          quot_d = 32'(prod_sum >> (32 + IdxW));
        end else begin
          rem_d   = IdxW'(hash_q - 32'(quot_q * 32'(Depth)));
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    hash_q    <= hash_d;
    cnt_q     <= cnt_d;
    step_q    <= step_d;
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
  end

  assign busy_o     = (state_q != S_IDLE);
  assign push_o     = (state_q == S_PUSH) && !full_i;
  assign push_req_o = req_q;
  assign push_idx_o = rem_q;

endmodule

// ===== rtl/fnvlp_back.sv =====
`timescale 1ns / 1ps
// back end: clears the slot store after reset, then probes it linearly for lookups and inserts
// depends on fnvlp_pkg and fnvlp_ram
module fnvlp_back #(
  parameter int unsigned Depth = fnvlp_pkg::TABLE_DEPTH,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  fnvlp_pkg::req_t req_i,
  input  logic [IdxW-1:0] idx_i,
  output logic            pop_o,
  input  logic [3:0]      unknown_kind_i,
  output logic            clearing_o,
  output logic            result_valid_o,
  output logic [1:0]      status_o,
  output logic [3:0]      result_kind_o,
  output logic [9:0]      result_offset_o
);
  import fnvlp_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0]      state_q, state_d;
  req_t            req_q, req_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] steps_q, steps_d;
  logic [CntW-1:0] used_q, used_d;
  logic            res_vld_q, res_vld_d;
  logic [1:0]      res_st_q, res_st_d;
  logic [3:0]      res_kind_q, res_kind_d;
  logic [9:0]      res_off_q, res_off_d;

  logic            we;
  logic [IdxW-1:0] waddr;
  slot_t           wdata;
  logic            re;
  slot_t           rdata;
  logic            key_eq;

  fnvlp_ram #(
    .Width ($bits(slot_t)),
    .Depth (Depth)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign key_eq = (rdata.len == req_q.slot.len) &&
                  (rdata.key_low == req_q.slot.key_low) &&
                  (rdata.key_high == req_q.slot.key_high);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    idx_d      = idx_q;
    steps_d    = steps_q;
    used_d     = used_q;
    res_vld_d  = 1'b0;
    res_st_d   = res_st_q;
    res_kind_d = res_kind_q;
    res_off_d  = res_off_q;
    we         = 1'b0;
    waddr      = idx_q;
    wdata      = req_q.slot;
    re         = 1'b0;
    pop_o      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          req_d   = req_i;
          idx_d   = idx_i;
          steps_d = '0;
          if (!req_i.ok || (req_i.op == OP_INSERT && used_q >= CntW'(Depth))) begin
            res_vld_d  = 1'b1;
            res_st_d   = (req_i.op == OP_INSERT) ? ST_FULL : ST_MISS;
            res_kind_d = (req_i.op == OP_INSERT) ? 4'd0 : unknown_kind_i;
            res_off_d  = 10'd0;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        re      = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        res_kind_d = 4'd0;
        res_off_d  = 10'd0;
        if (rdata.len == 4'd0) begin
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
          if (req_q.op == OP_INSERT) begin
            we       = 1'b1;
            used_d   = used_q + 1'b1;
            res_st_d = ST_INSERTED;
          end else begin
            res_st_d   = ST_MISS;
            res_kind_d = unknown_kind_i;
          end
        end else if (req_q.op == OP_LOOKUP && key_eq) begin
          res_vld_d  = 1'b1;
          res_st_d   = ST_HIT;
          res_kind_d = rdata.kind;
          res_off_d  = rdata.offset;
          state_d    = S_IDLE;
        end else if (steps_q == LastIdx) begin
          // every slot visited
          res_vld_d  = 1'b1;
          res_st_d   = (req_q.op == OP_INSERT) ? ST_FULL : ST_MISS;
          res_kind_d = (req_q.op == OP_INSERT) ? 4'd0 : unknown_kind_i;
          state_d    = S_IDLE;
        end else begin
          steps_d = steps_q + 1'b1;
          idx_d   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
          state_d = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      used_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      used_q    <= used_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    steps_q    <= steps_d;
    res_st_q   <= res_st_d;
    res_kind_q <= res_kind_d;
    res_off_q  <= res_off_d;
  end

  assign clearing_o      = (state_q == S_CLEAR);
  assign result_valid_o  = res_vld_q;
  assign status_o        = res_st_q;
  assign result_kind_o   = res_kind_q;
  assign result_offset_o = res_off_q;

endmodule

// ===== rtl/fnv1a_linear_probe_keyword_table_unit.sv =====
`timescale 1ns / 1ps
// top level of the fnv-1a keyword table: front end, request queue, probe engine, config register
// depends on fnvlp_pkg, fnvlp_front, fnvlp_queue, fnvlp_back
//
// A keyword table of TABLE_DEPTH slots, keys of 1 to 15 bytes, open addressing with linear
// probing from the FNV-1a home slot. A request is taken when start is high and busy is low; each
// request gives exactly one result beat on result_valid_o, one cycle wide, which cannot be stalled.
// After reset the slot store is cleared one slot per cycle, with busy high. The front end hashes
// the key one byte at a time (one multiply per byte), reduces the hash to a slot by reciprocal
// multiplication (partial products, quotient, remainder), then queues the request, waiting while
// the queue is full; it is busy until the request is queued. The probe engine pops a request, then
// reads and checks each slot visited on the single ram read port, and runs alongside the front end
// through a two-deep queue. A malformed length skips the hash and the probe; an insert into a
// full table skips the probe.
module fnv1a_linear_probe_keyword_table_unit #(
  parameter int unsigned TABLE_DEPTH = fnvlp_pkg::TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [63:0] key_low_i,
  input  logic [55:0] key_high_i,
  input  logic [3:0]  key_length_i,
  input  logic [3:0]  entry_kind_i,
  input  logic [9:0]  entry_offset_i,
  input  logic        unknown_kind_we_i,
  input  logic [3:0]  unknown_kind_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [3:0]  result_kind_o,
  output logic [9:0]  result_offset_o
);
  import fnvlp_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned QW   = $bits(req_t) + IdxW;

  logic            front_busy, clearing, take;
  logic            push, full, pop, empty;
  req_t            push_req, pop_req;
  logic [IdxW-1:0] push_idx, pop_idx;
  logic [3:0]      unknown_kind_q;

  assign busy = front_busy || clearing;
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unknown_kind_q <= 4'd0;
    end else if (unknown_kind_we_i) begin
      unknown_kind_q <= unknown_kind_i;
    end
  end

  fnvlp_front #(.Depth(TABLE_DEPTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .opcode_i       (opcode_i),
    .key_low_i      (key_low_i),
    .key_high_i     (key_high_i),
    .key_length_i   (key_length_i),
    .entry_kind_i   (entry_kind_i),
    .entry_offset_i (entry_offset_i),
    .busy_o         (front_busy),
    .push_o         (push),
    .push_req_o     (push_req),
    .push_idx_o     (push_idx),
    .full_i         (full)
  );

  fnvlp_queue #(.Width(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_req, push_idx}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  ({pop_req, pop_idx}),
    .empty_o     (empty)
  );

  fnvlp_back #(.Depth(TABLE_DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .req_i           (pop_req),
    .idx_i           (pop_idx),
    .pop_o           (pop),
    .unknown_kind_i  (unknown_kind_q),
    .clearing_o      (clearing),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .result_kind_o   (result_kind_o),
    .result_offset_o (result_offset_o)
  );

  // no result can come out while the store is still being cleared
  a_no_result_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !result_valid_o)
    else $error("result during clearing pass");

  // a taken request keeps the front end busy in the next cycle
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> busy)
    else $error("not busy after accepting a request");

  // inserted and full beats carry zero kind and offset
  a_insert_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_INSERTED || status_o == ST_FULL)) |->
      (result_kind_o == 4'd0 && result_offset_o == 10'd0))
    else $error("insert result with nonzero payload");

endmodule
